>>> src/blg_pkg.sv
// blg_pkg: shared types and constants for the battery level gauge
// status codes, register indexes, configuration and input word structs
// no dependencies
package blg_pkg;

    localparam int SAMPLE_W = 12;
    localparam int MARGIN_W = 10;
    localparam int SHIFT_W  = 3;
    localparam int LEVEL_W  = 3;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 12;

    typedef enum logic [2:0] {
        STATUS_FAULT       = 3'd0,
        STATUS_UNAVAILABLE = 3'd1,
        STATUS_CHARGING    = 3'd2,
        STATUS_COMPLETE    = 3'd3,
        STATUS_LOW         = 3'd4,
        STATUS_NORMAL      = 3'd5
    } status_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_THRESHOLD_ONE   = 3'd0,
        REG_THRESHOLD_TWO   = 3'd1,
        REG_THRESHOLD_THREE = 3'd2,
        REG_HYST_MARGIN     = 3'd3,
        REG_AVERAGE_SHIFT   = 3'd4,
        REG_LOW_LEVEL_LIMIT = 3'd5
    } reg_index_t;

    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_ONE   = 12'd2020;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_TWO   = 12'd2140;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_THREE = 12'd2260;
    localparam logic [MARGIN_W-1:0] RST_HYST_MARGIN     = 10'd20;
    localparam logic [SHIFT_W-1:0]  RST_AVERAGE_SHIFT   = 3'd3;
    localparam logic [LEVEL_W-1:0]  RST_LOW_LEVEL_LIMIT = 3'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold_one;
        logic [SAMPLE_W-1:0] threshold_two;
        logic [SAMPLE_W-1:0] threshold_three;
        logic [MARGIN_W-1:0] hysteresis_margin;
        logic [SHIFT_W-1:0]  average_shift;
        logic [LEVEL_W-1:0]  low_level_limit;
    } cfg_t;

    typedef struct packed {
        logic                read_valid;
        logic [SAMPLE_W-1:0] adc_sample;
        logic                supply_good;
        logic                charge_active;
    } item_t;

endpackage

>>> src/blg_cfg_regs.sv
// blg_cfg_regs: configuration register file of the battery level gauge
// depends on blg_pkg; writes beyond the last register are dropped
module blg_cfg_regs
    import blg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [INDEX_W-1:0]   wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_THRESHOLD_ONE:   cfg_next.threshold_one     = wr_data[SAMPLE_W-1:0];
                REG_THRESHOLD_TWO:   cfg_next.threshold_two     = wr_data[SAMPLE_W-1:0];
                REG_THRESHOLD_THREE: cfg_next.threshold_three   = wr_data[SAMPLE_W-1:0];
                REG_HYST_MARGIN:     cfg_next.hysteresis_margin = wr_data[MARGIN_W-1:0];
                REG_AVERAGE_SHIFT:   cfg_next.average_shift     = wr_data[SHIFT_W-1:0];
                REG_LOW_LEVEL_LIMIT: cfg_next.low_level_limit   = wr_data[LEVEL_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_one     <= RST_THRESHOLD_ONE;
            cfg_reg.threshold_two     <= RST_THRESHOLD_TWO;
            cfg_reg.threshold_three   <= RST_THRESHOLD_THREE;
            cfg_reg.hysteresis_margin <= RST_HYST_MARGIN;
            cfg_reg.average_shift     <= RST_AVERAGE_SHIFT;
            cfg_reg.low_level_limit   <= RST_LOW_LEVEL_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/blg_core.sv
// blg_core: running average, level with hysteresis and status classification
// depends on blg_pkg; state advances once per word passed to the result stage
module blg_core
    import blg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  item_t               item,
    input  logic                advance,
    output status_t             status,
    output logic [LEVEL_W-1:0]  level
);

    logic [SAMPLE_W-1:0] average_reg, average_next;
    logic                seeded_reg, seeded_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                read_seen_reg, read_seen_next;

    logic signed [SAMPLE_W:0] diff;
    logic signed [SAMPLE_W:0] bias;
    logic signed [SAMPLE_W:0] quot;
    logic [SAMPLE_W-1:0]      avg_new;
    logic [LEVEL_W-1:0]       raw_level;
    logic [SAMPLE_W-1:0]      up_thr;
    logic [SAMPLE_W-1:0]      dn_thr;
    logic [SAMPLE_W:0]        margin_ext;
    logic                     up_ok;
    logic                     dn_ok;
    logic [LEVEL_W-1:0]       level_upd;

    // difference over 2^shift, truncated toward zero
    always_comb begin
        diff = $signed({1'b0, item.adc_sample}) - $signed({1'b0, average_reg});
        bias = diff[SAMPLE_W] ? $signed((13'd1 << cfg.average_shift) - 13'd1)
                              : $signed(13'd0);
        quot = (diff + bias) >>> cfg.average_shift;
        avg_new = seeded_reg ? (average_reg + quot[SAMPLE_W-1:0]) : item.adc_sample;
    end

    always_comb begin
        raw_level = 3'd1;
        if (avg_new > cfg.threshold_one)   raw_level = 3'd2;
        if (avg_new > cfg.threshold_two)   raw_level = 3'd3;
        if (avg_new > cfg.threshold_three) raw_level = 3'd4;
    end

    always_comb begin
        case (level_reg)
            3'd1:    up_thr = cfg.threshold_one;
            3'd2:    up_thr = cfg.threshold_two;
            default: up_thr = cfg.threshold_three;
        endcase
        case (level_reg)
            3'd3:    dn_thr = cfg.threshold_two;
            3'd4:    dn_thr = cfg.threshold_three;
            default: dn_thr = cfg.threshold_one;
        endcase
        margin_ext = {3'b000, cfg.hysteresis_margin};
        up_ok = {1'b0, avg_new} > ({1'b0, up_thr} + margin_ext);
        dn_ok = ({1'b0, avg_new} + margin_ext) < {1'b0, dn_thr};

        level_upd = level_reg;
        if (level_reg == 3'd0 || level_reg > 3'd4) begin
            level_upd = raw_level;
        end else if (raw_level > level_reg && up_ok) begin
            level_upd = raw_level;
        end else if (raw_level < level_reg && level_reg >= 3'd2 && dn_ok) begin
            level_upd = raw_level;
        end
    end

    always_comb begin
        average_next   = average_reg;
        seeded_next    = seeded_reg;
        level_next     = level_reg;
        read_seen_next = read_seen_reg;
        if (item.read_valid) begin
            average_next   = avg_new;
            seeded_next    = 1'b1;
            level_next     = level_upd;
            read_seen_next = 1'b1;
        end
    end

    // status from the updated state and this word's pins
    always_comb begin
        if (item.charge_active && !item.supply_good) begin
            status = STATUS_FAULT;
        end else if (!read_seen_next) begin
            status = STATUS_UNAVAILABLE;
        end else if (!item.read_valid) begin
            status = STATUS_FAULT;
        end else if (item.supply_good) begin
            status = item.charge_active ? STATUS_CHARGING : STATUS_COMPLETE;
        end else if (level_next <= cfg.low_level_limit) begin
            status = STATUS_LOW;
        end else begin
            status = STATUS_NORMAL;
        end
        level = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            average_reg   <= '0;
            seeded_reg    <= 1'b0;
            level_reg     <= '0;
            read_seen_reg <= 1'b0;
        end else if (advance) begin
            average_reg   <= average_next;
            seeded_reg    <= seeded_next;
            level_reg     <= level_next;
            read_seen_reg <= read_seen_next;
        end
    end

endmodule

>>> src/battery_level_gauge_unit.sv
// battery_level_gauge_unit: top level of the battery level gauge
// depends on blg_pkg, blg_cfg_regs and blg_core
// m_valid rises once the accepted word moves from the input register to the result register
// one word per cycle while m_ready keeps up; the average and level update is combinational
// input and result registers; s_ready falls only while both hold words and m_ready is low
// reset: synchronous, active low; clears the pipeline, gauge state and loads register defaults
module battery_level_gauge_unit
    import blg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_read_valid,
    input  logic [SAMPLE_W-1:0] s_adc_sample,
    input  logic                s_supply_good,
    input  logic                s_charge_active,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_battery_status,
    output logic [LEVEL_W-1:0]  m_battery_level,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]   cfg_data
);

    cfg_t               cfg;
    item_t              in_word_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [LEVEL_W-1:0] level_reg;
    status_t            core_status;
    logic [LEVEL_W-1:0] core_level;
    logic               out_load;
    logic               advance;
    logic               in_load;

    assign cfg_ready = 1'b1;

    blg_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_load = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || advance;
    assign in_load  = s_valid && s_ready;

    blg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_word_reg),
        .advance (advance),
        .status  (core_status),
        .level   (core_level)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg.read_valid    <= s_read_valid;
            in_word_reg.adc_sample    <= s_adc_sample;
            in_word_reg.supply_good   <= s_supply_good;
            in_word_reg.charge_active <= s_charge_active;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= core_status;
            level_reg  <= core_level;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_battery_status = status_reg;
    assign m_battery_level  = level_reg;

endmodule
